[rtl/core/dqpb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqpb_pkg
// Shared constants, types and helpers of the DNS query packet builder.
// ----------------------------------------------------------------------------
package dqpb_pkg;

    // Label store geometry
    localparam int LABEL_MAX = 58;
    localparam int ADDR_W    = $clog2(LABEL_MAX);
    localparam int CNT_W     = $clog2(LABEL_MAX + 1);

    // Packet framing
    localparam int HDR_LEN  = 12;
    localparam int TAIL_LEN = 5;
    localparam int STEP_W   = $clog2(HDR_LEN);
    localparam logic [STEP_W-1:0] HDR_LAST  = STEP_W'(HDR_LEN - 1);
    localparam logic [STEP_W-1:0] TAIL_LAST = STEP_W'(TAIL_LEN - 1);

    // Tail step codes
    localparam logic [STEP_W-1:0] TL_ROOT    = STEP_W'(0);
    localparam logic [STEP_W-1:0] TL_TYPE_HI = STEP_W'(1);
    localparam logic [STEP_W-1:0] TL_TYPE_LO = STEP_W'(2);
    localparam logic [STEP_W-1:0] TL_CLS_HI  = STEP_W'(3);

    // Header step codes
    localparam logic [STEP_W-1:0] HS_ID_HI   = STEP_W'(0);
    localparam logic [STEP_W-1:0] HS_ID_LO   = STEP_W'(1);
    localparam logic [STEP_W-1:0] HS_FLAGS   = STEP_W'(2);
    localparam logic [STEP_W-1:0] HS_QD_LO   = STEP_W'(5);

    // Character codes
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_DOT = 8'h2E;
    localparam logic [7:0] CHAR_D0  = 8'h30;
    localparam logic [7:0] CHAR_D9  = 8'h39;

    // Header byte values
    localparam logic [7:0] FLAG_RD  = 8'h01;   // recursion desired
    localparam logic [7:0] QD_ONE   = 8'h01;   // one question
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    // Configuration register indexes
    localparam logic CFG_QTYPE  = 1'b0;
    localparam logic CFG_QCLASS = 1'b1;

    // Kind of the accepted character
    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_DOT  = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    // Query type and class as configured
    typedef struct packed {
        logic [15:0] qtype;
        logic [15:0] qclass;
    } t_qcfg;

    // Label store access from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_buf_req;

    // Sequencer status
    typedef struct packed {
        logic             idle;
        logic             in_packet;
        logic [CNT_W-1:0] label_count;
    } t_seq_stat;

    // Byte of the fixed 12-byte header at a given step
    function automatic logic [7:0] hdr_byte(input logic [STEP_W-1:0] idx,
                                            input logic [15:0] id);
        logic [7:0] b;
        b = BYTE_ZERO;
        case (idx)
            HS_ID_HI: b = id[15:8];
            HS_ID_LO: b = id[7:0];
            HS_FLAGS: b = FLAG_RD;
            HS_QD_LO: b = QD_ONE;
            default:  b = BYTE_ZERO;
        endcase
        return b;
    endfunction

endpackage

[rtl/core/dqpb_label_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqpb_label_buf
// Label store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dqpb_label_buf (
    input  logic                          i_clk,
    input  dqpb_pkg::t_buf_req            i_req,
    output logic [7:0]                    o_rdata
);

    logic [7:0] r_mem [dqpb_pkg::LABEL_MAX];
    logic [7:0] r_rdata;

    // Write characters, read back one entry per request
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/dqpb_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqpb_seq
// Sequencer: takes name characters, fills the label store, and emits the
// header, the length-prefixed labels and the question tail byte by byte.
// ----------------------------------------------------------------------------
module dqpb_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dqpb_pkg::t_qcfg            i_cfg,
    // Input word: [7:0] name_byte, [23:8] query_id
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [23:0]                i_s_tdata,
    // Label store
    output dqpb_pkg::t_buf_req         o_buf_req,
    input  logic [7:0]                 i_rdata,
    // Output word
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [7:0]                 o_m_tdata,
    output logic                       o_m_tlast,
    output logic [1:0]                 o_m_tuser,
    output dqpb_pkg::t_seq_stat        o_stat
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_HDR  = 5'b00010,
        ST_LEN  = 5'b00100,
        ST_DATA = 5'b01000,
        ST_TAIL = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_in_packet, n_in_packet;
    logic [dqpb_pkg::CNT_W-1:0]      r_count, n_count;
    logic                            r_ovf, n_ovf;
    logic                            r_dig, n_dig;
    logic [dqpb_pkg::STEP_W-1:0]     r_step, n_step;
    logic [dqpb_pkg::CNT_W-1:0]      r_rd_idx, n_rd_idx;
    dqpb_pkg::t_kind                 r_kind, n_kind;
    logic [15:0]                     r_id, n_id;

    logic                            r_out_valid;
    logic [7:0]                      r_out_byte;
    logic                            r_out_last;
    logic                            r_out_ovf;
    logic                            r_out_num;

    logic                            w_accept;
    logic                            w_load;
    dqpb_pkg::t_kind                 w_kind;
    logic [7:0]                      w_char;
    logic [dqpb_pkg::CNT_W-1:0]      w_base_cnt;
    logic [dqpb_pkg::CNT_W-1:0]      w_rd_next;
    logic                            w_emit;
    logic [7:0]                      w_emit_byte;
    logic                            w_emit_last;
    dqpb_pkg::t_buf_req              w_req;

    assign w_char     = i_s_tdata[7:0];
    assign w_accept   = i_s_tvalid && (r_state == ST_IDLE);
    assign w_load     = !r_out_valid || i_m_tready;
    assign w_base_cnt = r_in_packet ? r_count : '0;
    assign w_rd_next  = r_rd_idx + dqpb_pkg::CNT_W'(1);

    // Classify the incoming character
    always_comb begin
        if (w_char == dqpb_pkg::CHAR_NUL) begin
            w_kind = dqpb_pkg::KIND_END;
        end else if (w_char == dqpb_pkg::CHAR_DOT) begin
            w_kind = dqpb_pkg::KIND_DOT;
        end else begin
            w_kind = dqpb_pkg::KIND_CHAR;
        end
    end

    // Next state, store access and byte emission
    always_comb begin
        n_state     = r_state;
        n_in_packet = r_in_packet;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_dig       = r_dig;
        n_step      = r_step;
        n_rd_idx    = r_rd_idx;
        n_kind      = r_kind;
        n_id        = r_id;
        w_req       = '0;
        w_emit      = 1'b0;
        w_emit_byte = dqpb_pkg::BYTE_ZERO;
        w_emit_last = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_kind      = w_kind;
                    n_id        = i_s_tdata[23:8];
                    n_in_packet = 1'b1;
                    n_count     = w_base_cnt;
                    n_ovf       = r_in_packet ? r_ovf : 1'b0;
                    n_dig       = r_in_packet ? r_dig : 1'b1;
                    n_step      = '0;
                    if (w_kind == dqpb_pkg::KIND_CHAR) begin
                        if (w_char < dqpb_pkg::CHAR_D0 || w_char > dqpb_pkg::CHAR_D9) begin
                            n_dig = 1'b0;
                        end
                        // Store the character, or drop it past the label limit
                        if (w_base_cnt < dqpb_pkg::CNT_W'(dqpb_pkg::LABEL_MAX)) begin
                            w_req.we    = 1'b1;
                            w_req.waddr = w_base_cnt[dqpb_pkg::ADDR_W-1:0];
                            w_req.wdata = w_char;
                            n_count     = w_base_cnt + dqpb_pkg::CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (!r_in_packet) begin
                        n_state = ST_HDR;
                    end else if (w_kind != dqpb_pkg::KIND_CHAR) begin
                        if (w_base_cnt != '0) begin
                            n_state = ST_LEN;
                        end else if (w_kind == dqpb_pkg::KIND_END) begin
                            n_state = ST_TAIL;
                        end
                    end
                end
            end
            ST_HDR: begin
                if (w_load) begin
                    w_emit      = 1'b1;
                    w_emit_byte = dqpb_pkg::hdr_byte(r_step, r_id);
                    if (r_step == dqpb_pkg::HDR_LAST) begin
                        n_step = '0;
                        if (r_kind == dqpb_pkg::KIND_CHAR) begin
                            n_state = ST_IDLE;
                        end else if (r_count != '0) begin
                            n_state = ST_LEN;
                        end else if (r_kind == dqpb_pkg::KIND_END) begin
                            n_state = ST_TAIL;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_step = r_step + dqpb_pkg::STEP_W'(1);
                    end
                end
            end
            ST_LEN: begin
                // Emit the length byte and fetch the first character
                if (w_load) begin
                    w_emit      = 1'b1;
                    w_emit_byte = 8'(r_count);
                    w_req.re    = 1'b1;
                    w_req.raddr = '0;
                    n_rd_idx    = '0;
                    n_state     = ST_DATA;
                end
            end
            ST_DATA: begin
                // Emit the fetched character, prefetch the next one
                if (w_load) begin
                    w_emit      = 1'b1;
                    w_emit_byte = i_rdata;
                    if (w_rd_next < r_count) begin
                        w_req.re    = 1'b1;
                        w_req.raddr = w_rd_next[dqpb_pkg::ADDR_W-1:0];
                        n_rd_idx    = w_rd_next;
                    end else begin
                        n_count = '0;
                        n_state = (r_kind == dqpb_pkg::KIND_END) ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_TAIL: begin
                if (w_load) begin
                    w_emit = 1'b1;
                    case (r_step)
                        dqpb_pkg::TL_ROOT:    w_emit_byte = dqpb_pkg::BYTE_ZERO;
                        dqpb_pkg::TL_TYPE_HI: w_emit_byte = i_cfg.qtype[15:8];
                        dqpb_pkg::TL_TYPE_LO: w_emit_byte = i_cfg.qtype[7:0];
                        dqpb_pkg::TL_CLS_HI:  w_emit_byte = i_cfg.qclass[15:8];
                        default:              w_emit_byte = i_cfg.qclass[7:0];
                    endcase
                    if (r_step == dqpb_pkg::TAIL_LAST) begin
                        w_emit_last = 1'b1;
                        n_in_packet = 1'b0;
                        n_count     = '0;
                        n_step      = '0;
                        n_state     = ST_IDLE;
                    end else begin
                        n_step = r_step + dqpb_pkg::STEP_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_packet <= 1'b0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_dig       <= 1'b1;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_packet <= n_in_packet;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_dig       <= n_dig;
            r_step      <= n_step;
            if (w_load) begin
                r_out_valid <= w_emit;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        r_kind   <= n_kind;
        r_id     <= n_id;
        if (w_load && w_emit) begin
            r_out_byte <= w_emit_byte;
            r_out_last <= w_emit_last;
            r_out_ovf  <= w_emit_last && r_ovf;
            r_out_num  <= w_emit_last && r_dig;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_buf_req  = w_req;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = {r_out_num, r_out_ovf};

    assign o_stat.idle        = (r_state == ST_IDLE);
    assign o_stat.in_packet   = r_in_packet;
    assign o_stat.label_count = r_count;

endmodule

[rtl/core/dns_query_packet_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_packet_builder
// Builds a DNS query packet from a NUL-terminated host name, one byte a word.
//
//  Channel   Direction  Word contents (lowest bit up)
//  s_axis    in         tdata: name_byte[7:0], query_id[23:8]
//  m_axis    out        tdata: packet_byte; tlast: packet_end;
//                       tuser: label_overflow[0], numeric_name[1]
//  i_cfg_*   in         idx 0: query_type, idx 1: query_class (16 bit)
//
// A name character is taken and written to the label store, or dropped past
// the label limit, in the same cycle. The first character of a name, a dot
// ending a nonempty label and the NUL each hold the input while output bytes
// go out: 12 header bytes, count+1 label bytes (one store read per character)
// and 5 tail bytes on the NUL. Output stalls hold the sequencer; the output
// register keeps the word. Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dns_query_packet_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // Name input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // name_byte[7:0], query_id[23:8]
    // Packet output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // packet_byte[7:0]
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // label_overflow[0], numeric_name[1]
);

    logic [15:0]          r_qtype;
    logic [15:0]          r_qclass;
    dqpb_pkg::t_qcfg      w_cfg;
    dqpb_pkg::t_buf_req   w_buf_req;
    dqpb_pkg::t_seq_stat  w_stat;
    logic [7:0]           w_rdata;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qtype  <= 16'd1;
            r_qclass <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dqpb_pkg::CFG_QTYPE:  r_qtype  <= i_cfg_data;
                dqpb_pkg::CFG_QCLASS: r_qclass <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cfg.qtype  = r_qtype;
    assign w_cfg.qclass = r_qclass;

    dqpb_label_buf u_buf (
        .i_clk   (i_clk),
        .i_req   (w_buf_req),
        .o_rdata (w_rdata)
    );

    dqpb_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .o_buf_req  (w_buf_req),
        .i_rdata    (w_rdata),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tuser  (m_axis_tuser),
        .o_stat     (w_stat)
    );

    // Label count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.label_count <= dqpb_pkg::CNT_W'(dqpb_pkg::LABEL_MAX))
        else $error("label count beyond store depth");

    // An accepted NUL always leads into output work
    a_nul_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[7:0] == dqpb_pkg::CHAR_NUL)
        |=> !s_axis_tready)
        else $error("NUL accepted without flush");

    // Output work only happens inside an open packet
    a_busy_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_stat.idle |-> w_stat.in_packet)
        else $error("sequencer busy with no packet open");

    // Hold the output word while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser)))
        else $error("output word changed while stalled");

    // Flags only travel on the final word
    a_flags_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == 2'b00))
        else $error("flags set on a non-final word");

endmodule
